[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the thread count tuner checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while in reset
`define ATCT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, held off while in reset
`define ATCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/atct_pkg.sv]
// ----------------------------------------------------------------------------
// atct_pkg
// Shared constants, state type and control/status bundles of the tuner.
// ----------------------------------------------------------------------------
`default_nettype none

package atct_pkg;

  localparam int unsigned MAX_LEVELS_DEF = 64;

  localparam int unsigned MEAN_W     = 32;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned LVL_W      = 7;
  localparam int unsigned DVD_W      = 48;
  localparam int unsigned DSR_W      = CNT_W + 1;
  localparam int unsigned DIV_STEPS  = DVD_W;
  localparam int unsigned DCNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned ENTRY_W    = MEAN_W + CNT_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_THR_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LVL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SMP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACT_MAX = 2'd3;

  localparam logic             THR_EN_RST  = 1'b1;
  localparam logic [LVL_W-1:0] MIN_LVL_RST = 7'd1;
  localparam logic [CNT_W-1:0] MIN_SMP_RST = 16'd1;
  localparam logic [LVL_W-1:0] ACT_MAX_RST = 7'd64;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_SUBMIT = 1'b1;

  localparam logic [CNT_W-1:0]  CNT_SAT     = '1;
  localparam logic [MEAN_W-1:0] MEAN_UNSEEN = '1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISP,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_WR,
    ST_SRD,
    ST_SCHK,
    ST_RESP
  } atct_state_t;

  typedef struct packed {
    logic load_item;
    logic scan_init;
    logic scan_chk;
    logic ans_fixed;
    logic mul;
    logic div_init;
    logic div_step;
    logic wr;
    logic out_load;
  } atct_ctl_t;

  typedef struct packed {
    logic is_submit;
    logic lvl_ok;
    logic scan_needed;
    logic scan_done;
    logic div_last;
    logic out_free;
  } atct_sts_t;

endpackage

`default_nettype wire

[rtl/adaptive_thread_count_tuner.sv]
// Query, threading off or already settled: the answer is fixed at dispatch, with no scan.
// Query with scan: each level examined takes a read of the store (read port) and a check;
//   the scan stops at the first under-sampled level, a slower level or the last level.
// Submit: a valid level's mean is updated by a multiply and a 48-step serial divider; no result beat.
// One beat at a time; reset is synchronous and clears all valid bits at once.
// ----------------------------------------------------------------------------
// adaptive_thread_count_tuner
// Chooses the parallelism level to run next from running mean run times.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_thread_count_tuner
  import atct_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // level[6:0], run_time[38:7]
  input  wire logic [0:0]            in_tuser,   // cmd[0]
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // thread_count[6:0], is_settled[7]
);

  atct_ctl_t ctl;
  atct_sts_t sts;

  atct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  atct_datapath #(
    .MAX_LEVELS (MAX_LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .ctl        (ctl),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[rtl/atct_ctrl.sv]
// ----------------------------------------------------------------------------
// atct_ctrl
// Sequencer of the tuner: dispatches a beat to the update or scan sequence, or straight to the result.
// ----------------------------------------------------------------------------
`default_nettype none

module atct_ctrl
  import atct_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_tvalid,
  output logic           in_tready,
  input  wire atct_sts_t sts,
  output atct_ctl_t      ctl
);

  atct_state_t state_r;
  atct_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DISP;
      end
      ST_DISP: begin
        if (sts.is_submit) begin
          state_nxt = sts.lvl_ok ? ST_MUL : ST_IDLE;
        end else begin
          state_nxt = sts.scan_needed ? ST_SRD : ST_RESP;
        end
      end
      ST_MUL:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.div_last) state_nxt = ST_WR;
      end
      ST_WR:   state_nxt = ST_IDLE;
      ST_SRD:  state_nxt = ST_SCHK;
      ST_SCHK: state_nxt = sts.scan_done ? ST_RESP : ST_SRD;
      ST_RESP: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready     = rst_n;
        ctl.load_item = in_tvalid;
      end
      ST_DISP: begin
        ctl.scan_init = !sts.is_submit && sts.scan_needed;
        ctl.ans_fixed = !sts.is_submit && !sts.scan_needed;
      end
      ST_MUL:  ctl.mul      = 1'b1;
      ST_LOAD: ctl.div_init = 1'b1;
      ST_DIV:  ctl.div_step = 1'b1;
      ST_WR:   ctl.wr       = 1'b1;
      ST_SCHK: ctl.scan_chk = 1'b1;
      ST_RESP: ctl.out_load = sts.out_free;
      default: ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/atct_datapath.sv]
// ----------------------------------------------------------------------------
// atct_datapath
// Level store, settings, mean update (multiply and serial divide), scan
// compare and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module atct_datapath
  import atct_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic [0:0]            in_tuser,
  input  wire atct_ctl_t             ctl,
  output atct_sts_t                  sts,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int unsigned LW = $clog2(MAX_LEVELS);
  localparam int unsigned MW = $clog2(MAX_LEVELS + 1);
  localparam int unsigned EW = (MW > LVL_W) ? MW : LVL_W;

  // settings
  logic             thr_en_r;
  logic [LVL_W-1:0] min_lvl_r;
  logic [CNT_W-1:0] min_smp_r;
  logic [LVL_W-1:0] act_max_r;

  // current beat
  logic              cmd_r;
  logic [LVL_W-1:0]  lvl_r;
  logic [MEAN_W-1:0] rt_r;
  logic [LVL_W-1:0]  lvl_in;

  // level store
  logic [ENTRY_W-1:0]    mem_r [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] vld_r;
  logic [ENTRY_W-1:0]    rd_r;
  logic                  rd_vld_r;
  logic [MEAN_W-1:0]     rd_mean;
  logic [CNT_W-1:0]      rd_cnt;
  logic [LW-1:0]         addr_r;

  // mean update
  logic [DVD_W-1:0]  prod_r;
  logic [DVD_W-1:0]  prod_w;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_inc;
  logic [DVD_W-1:0]  dvd_r;
  logic [DSR_W-1:0]  rem_r;
  logic [DSR_W-1:0]  dsr_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [DSR_W:0]    rem_sh;
  logic [DSR_W:0]    rem_dif;
  logic              q_bit;

  // scan
  logic [EW-1:0]     am_ext;
  logic [EW-1:0]     ml_ext;
  logic [EW-1:0]     lvl_ext;
  logic [EW-1:0]     m_w;
  logic [EW-1:0]     lo_w;
  logic [EW-1:0]     i_ext;
  logic [EW-1:0]     i_p1;
  logic              prime_r;
  logic [MEAN_W-1:0] prev_r;
  logic              short_s;
  logic              slower;
  logic              at_end;
  logic              scan_done;

  // answer and result
  logic             settled_r;
  logic [LVL_W-1:0] best_r;
  logic [LVL_W-1:0] ans_r;
  logic             out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  assign lvl_in  = in_tdata[LVL_W-1:0];
  assign am_ext  = EW'(act_max_r);
  assign ml_ext  = EW'(min_lvl_r);
  assign lvl_ext = EW'(lvl_r);

  always_comb begin
    if (am_ext == '0) begin
      m_w = EW'(1);
    end else if (am_ext > EW'(MAX_LEVELS)) begin
      m_w = EW'(MAX_LEVELS);
    end else begin
      m_w = am_ext;
    end
    if (ml_ext == '0) begin
      lo_w = EW'(1);
    end else if (ml_ext > m_w) begin
      lo_w = m_w;
    end else begin
      lo_w = ml_ext;
    end
  end

  assign rd_mean = rd_vld_r ? rd_r[ENTRY_W-1:CNT_W] : MEAN_UNSEEN;
  assign rd_cnt  = rd_vld_r ? rd_r[CNT_W-1:0] : '0;
  assign prod_w  = DVD_W'(rd_mean) * DVD_W'(rd_cnt);
  assign cnt_inc = (cnt_r == CNT_SAT) ? cnt_r : cnt_r + CNT_W'(1);

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign q_bit   = rem_sh >= {1'b0, dsr_r};
  assign rem_dif = rem_sh - {1'b0, dsr_r};

  assign i_ext     = EW'(addr_r);
  assign i_p1      = i_ext + EW'(1);
  assign short_s   = rd_cnt < min_smp_r;
  assign slower    = (addr_r != '0) && (rd_mean > prev_r);
  assign at_end    = i_ext == (m_w - EW'(1));
  assign scan_done = !prime_r && (short_s || slower || at_end);

  always_comb begin
    sts.is_submit   = cmd_r == CMD_SUBMIT;
    sts.lvl_ok      = (lvl_ext != '0) && (lvl_ext <= m_w);
    sts.scan_needed = thr_en_r && !settled_r;
    sts.scan_done   = scan_done;
    sts.div_last    = dcnt_r == DCNT_W'(DIV_STEPS - 1);
    sts.out_free    = !out_valid_r || out_tready;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_en_r    <= THR_EN_RST;
      min_lvl_r   <= MIN_LVL_RST;
      min_smp_r   <= MIN_SMP_RST;
      act_max_r   <= ACT_MAX_RST;
      vld_r       <= '0;
      settled_r   <= 1'b0;
      best_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THR_EN:  thr_en_r  <= cfg_wdata[0];
          CFG_MIN_LVL: min_lvl_r <= cfg_wdata[LVL_W-1:0];
          CFG_MIN_SMP: min_smp_r <= cfg_wdata[CNT_W-1:0];
          CFG_ACT_MAX: act_max_r <= cfg_wdata[LVL_W-1:0];
          default: ;
        endcase
      end
      if (ctl.wr) vld_r[addr_r] <= 1'b1;
      if (ctl.scan_chk && scan_done && !short_s) begin
        settled_r <= 1'b1;
        best_r    <= slower ? i_ext[LVL_W-1:0] : m_w[LVL_W-1:0];
      end
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // store
  always_ff @(posedge clk) begin
    if (ctl.wr) mem_r[addr_r] <= {dvd_r[MEAN_W-1:0], cnt_inc};
    rd_r     <= mem_r[addr_r];
    rd_vld_r <= vld_r[addr_r];
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_r  <= in_tuser[0];
      lvl_r  <= lvl_in;
      rt_r   <= in_tdata[LVL_W +: MEAN_W];
      addr_r <= LW'(EW'(lvl_in) - EW'(1));
    end
    if (ctl.scan_init) begin
      if (lo_w > EW'(1)) begin
        addr_r  <= LW'(lo_w - EW'(2));
        prime_r <= 1'b1;
      end else begin
        addr_r  <= '0;
        prime_r <= 1'b0;
      end
    end
    if (ctl.scan_chk) begin
      if (!scan_done) begin
        prev_r  <= rd_mean;
        addr_r  <= addr_r + LW'(1);
        prime_r <= 1'b0;
      end else if (short_s) begin
        ans_r <= i_p1[LVL_W-1:0];
      end else if (slower) begin
        ans_r <= i_ext[LVL_W-1:0];
      end else begin
        ans_r <= m_w[LVL_W-1:0];
      end
    end
    if (ctl.ans_fixed) ans_r <= thr_en_r ? best_r : LVL_W'(1);
    if (ctl.mul) begin
      prod_r <= prod_w;
      cnt_r  <= rd_cnt;
    end
    if (ctl.div_init) begin
      dvd_r  <= prod_r + DVD_W'(rt_r);
      dsr_r  <= {1'b0, cnt_r} + DSR_W'(1);
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (ctl.div_step) begin
      rem_r  <= q_bit ? rem_dif[DSR_W-1:0] : rem_sh[DSR_W-1:0];
      dvd_r  <= {dvd_r[DVD_W-2:0], q_bit};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (ctl.out_load) out_data_r <= {settled_r, ans_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[rtl/atct_checker.sv]
// ----------------------------------------------------------------------------
// atct_checker
// Port-level checks of the tuner, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module atct_checker
  import atct_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [0:0]            in_tuser,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  `ATCT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ATCT_ASSERT_NOW(a_count_nonzero, out_tvalid, out_tdata[LVL_W-1:0] != '0)
  `ATCT_ASSERT_NEXT(a_submit_silent, in_tvalid && in_tready && in_tuser[0] && !out_tvalid, !out_tvalid)
  `ATCT_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)

endmodule

bind adaptive_thread_count_tuner atct_checker u_atct_checker (.*);

`default_nettype wire
